@@ rtl/aoc_pkg.sv @@
// ----------------------------------------------------------------------------
// Alpha-over compositor package
// Request types, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aoc_pkg;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 13;
    localparam int SHIFT_W = 14;
    localparam int CFG_W   = 14;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_CANVAS_W  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CANVAS_H  = 3'd1;
    localparam logic [IDX_W-1:0] REG_OVERLAY_W = 3'd2;
    localparam logic [IDX_W-1:0] REG_OVERLAY_H = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_X   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y   = 3'd5;

    localparam logic [DIM_W-1:0] CANVAS_RESET = 13'd4096;
    localparam logic [PIX_W-1:0] FULL_SCALE   = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] bg_c0;
        logic [PIX_W-1:0] bg_c1;
        logic [PIX_W-1:0] bg_c2;
        logic [PIX_W-1:0] bg_c3;
        logic [PIX_W-1:0] fg_c0;
        logic [PIX_W-1:0] fg_c1;
        logic [PIX_W-1:0] fg_c2;
        logic [PIX_W-1:0] fg_alpha;
    } t_in_req;

    typedef struct packed {
        logic [PIX_W-1:0] out_c0;
        logic [PIX_W-1:0] out_c1;
        logic [PIX_W-1:0] out_c2;
        logic [PIX_W-1:0] out_c3;
        logic             covered;
        logic             frame_last;
    } t_out_req;

endpackage

`default_nettype wire

@@ rtl/alpha_over_compositor.sv @@
// ----------------------------------------------------------------------------
// Alpha-over compositor
// Each accepted request passes the input register, then the result register.
// Throughput: one pixel per cycle unless stalled; position compare at the input
// register; covered pixels blend all four channels into the result register.
// Reset: synchronous active-low; clears raster counters, pipeline valids and
// restores canvas 4096x4096, empty overlay, zero shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alpha_over_compositor
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire t_in_req                 i_in_req,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output t_out_req                     o_out_req
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = ((CW + 2) > 15) ? (CW + 2) : 15;

    function automatic logic [PIX_W-1:0] blend(
        input logic [PIX_W-1:0] bg,
        input logic [PIX_W-1:0] fg,
        input logic [PIX_W-1:0] a
    );
        logic [2*PIX_W-1:0] x;
        logic [2*PIX_W:0]   t;
        x = ({{PIX_W{1'b0}}, bg} * {{PIX_W{1'b0}}, FULL_SCALE - a})
          + ({{PIX_W{1'b0}}, fg} * {{PIX_W{1'b0}}, a});
        t = {1'b0, x} + {{(PIX_W+1){1'b0}}, x[2*PIX_W-1:PIX_W]} + 17'd1;
        return t[2*PIX_W-1:PIX_W];
    endfunction

    logic [DIM_W-1:0]          r_canvas_w;
    logic [DIM_W-1:0]          r_canvas_h;
    logic [DIM_W-1:0]          r_overlay_w;
    logic [DIM_W-1:0]          r_overlay_h;
    logic signed [SHIFT_W-1:0] r_shift_x;
    logic signed [SHIFT_W-1:0] r_shift_y;

    logic [CW-1:0]             r_col;
    logic [CW-1:0]             r_row;
    logic [CW-1:0]             n_col;
    logic [CW-1:0]             n_row;

    logic                      r_s1_valid;
    t_in_req                   r_s1_req;
    logic                      r_s1_cov;
    logic                      r_s1_last;

    logic                      r_s2_valid;
    t_out_req                  r_s2_req;
    t_out_req                  n_s2_req;

    logic                      s2_ready;
    logic                      s1_ready;
    logic                      in_acc;

    logic [EW-1:0]             canvas_w;
    logic [EW-1:0]             canvas_h;
    logic signed [EW-1:0]      dx;
    logic signed [EW-1:0]      dy;
    logic                      cov;
    logic                      col_end;
    logic                      row_end;

    assign s2_ready    = !r_s2_valid || !i_out_stall;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign in_acc      = i_in_valid && s1_ready;
    assign o_in_stall  = !s1_ready;
    assign o_out_valid = r_s2_valid;
    assign o_out_req   = r_s2_req;

    always_comb begin
        canvas_w = EW'(r_canvas_w);
        if (canvas_w == '0) begin
            canvas_w = EW'(1);
        end else if (canvas_w > EW'(MAX_DIM)) begin
            canvas_w = EW'(MAX_DIM);
        end
        canvas_h = EW'(r_canvas_h);
        if (canvas_h == '0) begin
            canvas_h = EW'(1);
        end else if (canvas_h > EW'(MAX_DIM)) begin
            canvas_h = EW'(MAX_DIM);
        end

        dx  = $signed(EW'(r_col)) - EW'(r_shift_x);
        dy  = $signed(EW'(r_row)) - EW'(r_shift_y);
        cov = !dx[EW-1] && (dx < $signed(EW'(r_overlay_w)))
           && !dy[EW-1] && (dy < $signed(EW'(r_overlay_h)));

        col_end = (EW'(r_col) + EW'(1)) >= canvas_w;
        row_end = (EW'(r_row) + EW'(1)) >= canvas_h;

        n_col = r_col;
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_comb begin
        if (r_s1_cov) begin
            n_s2_req.out_c0 = blend(r_s1_req.bg_c0, r_s1_req.fg_c0, r_s1_req.fg_alpha);
            n_s2_req.out_c1 = blend(r_s1_req.bg_c1, r_s1_req.fg_c1, r_s1_req.fg_alpha);
            n_s2_req.out_c2 = blend(r_s1_req.bg_c2, r_s1_req.fg_c2, r_s1_req.fg_alpha);
            n_s2_req.out_c3 = blend(r_s1_req.bg_c3, r_s1_req.fg_alpha,
                                    r_s1_req.fg_alpha);
        end else begin
            n_s2_req.out_c0 = r_s1_req.bg_c0;
            n_s2_req.out_c1 = r_s1_req.bg_c1;
            n_s2_req.out_c2 = r_s1_req.bg_c2;
            n_s2_req.out_c3 = r_s1_req.bg_c3;
        end
        n_s2_req.covered    = r_s1_cov;
        n_s2_req.frame_last = r_s1_last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w  <= CANVAS_RESET;
            r_canvas_h  <= CANVAS_RESET;
            r_overlay_w <= '0;
            r_overlay_h <= '0;
            r_shift_x   <= '0;
            r_shift_y   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_CANVAS_W:  r_canvas_w  <= i_cfg_wdata[DIM_W-1:0];
                REG_CANVAS_H:  r_canvas_h  <= i_cfg_wdata[DIM_W-1:0];
                REG_OVERLAY_W: r_overlay_w <= i_cfg_wdata[DIM_W-1:0];
                REG_OVERLAY_H: r_overlay_h <= i_cfg_wdata[DIM_W-1:0];
                REG_SHIFT_X:   r_shift_x   <= $signed(i_cfg_wdata[SHIFT_W-1:0]);
                REG_SHIFT_Y:   r_shift_y   <= $signed(i_cfg_wdata[SHIFT_W-1:0]);
                default: ;
            endcase
        end
    end

    // raster position and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s2_ready) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req  <= i_in_req;
            r_s1_cov  <= cov;
            r_s1_last <= col_end && row_end;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_req <= n_s2_req;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_alpha_over_compositor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over compositor testbench
// Streams pixel requests through a series of canvas, overlay and shift layouts.
// The sender works in bursts and the receiver stalls at random. A raster and
// blend predictor checks every result in order.
// ----------------------------------------------------------------------------

module tb_alpha_over_compositor;
    import aoc_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int TOTAL_PIXELS = 850;
    localparam int MAX_REPORTS  = 10;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    class pixel_scoreboard;
        logic [DIM_W-1:0]          canvas_w;
        logic [DIM_W-1:0]          canvas_h;
        logic [DIM_W-1:0]          overlay_w;
        logic [DIM_W-1:0]          overlay_h;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        int                        col;
        int                        row;
        int                        mismatches;
        int                        results_seen;
        t_out_req                  expected_q[$];

        function new();
            canvas_w     = CANVAS_RESET;
            canvas_h     = CANVAS_RESET;
            overlay_w    = '0;
            overlay_h    = '0;
            shift_x      = '0;
            shift_y      = '0;
            col          = 0;
            row          = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_CANVAS_W:  canvas_w  = data[DIM_W-1:0];
                REG_CANVAS_H:  canvas_h  = data[DIM_W-1:0];
                REG_OVERLAY_W: overlay_w = data[DIM_W-1:0];
                REG_OVERLAY_H: overlay_h = data[DIM_W-1:0];
                REG_SHIFT_X:   shift_x   = data;
                REG_SHIFT_Y:   shift_y   = data;
                default: ;
            endcase
        endfunction

        function int clamp_dim(logic [DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return int'(v);
        endfunction

        function bit in_window(int pos, int shift, int size);
            return (pos - shift >= 0) && (pos - shift < size);
        endfunction

        function logic [PIX_W-1:0] blend(int bg, int fg, int a);
            int full;
            full = int'(FULL_SCALE);
            return PIX_W'((bg * (full - a) + fg * a) / full);
        endfunction

        function string show(t_out_req r);
            return $sformatf("%02h %02h %02h %02h cov=%0b last=%0b",
                             r.out_c0, r.out_c1, r.out_c2, r.out_c3, r.covered, r.frame_last);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%s", msg);
        endfunction

        function void note_input(t_in_req px);
            int       w;
            int       h;
            bit       cov;
            bit       col_end;
            bit       row_end;
            t_out_req e;
            w       = clamp_dim(canvas_w);
            h       = clamp_dim(canvas_h);
            cov     = in_window(col, int'(shift_x), int'(overlay_w)) &&
                      in_window(row, int'(shift_y), int'(overlay_h));
            col_end = (col + 1 >= w);
            row_end = (row + 1 >= h);
            e.out_c0     = cov ? blend(px.bg_c0, px.fg_c0, px.fg_alpha) : px.bg_c0;
            e.out_c1     = cov ? blend(px.bg_c1, px.fg_c1, px.fg_alpha) : px.bg_c1;
            e.out_c2     = cov ? blend(px.bg_c2, px.fg_c2, px.fg_alpha) : px.bg_c2;
            e.out_c3     = cov ? blend(px.bg_c3, px.fg_alpha, px.fg_alpha) : px.bg_c3;
            e.covered    = cov;
            e.frame_last = col_end && row_end;
            expected_q.push_back(e);
            if (col_end) begin
                col = 0;
                row = row_end ? 0 : row + 1;
            end else begin
                col++;
            end
        endfunction

        function void check_result(t_out_req got);
            t_out_req e;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d unexpected: got %s", results_seen, show(got)));
                return;
            end
            e = expected_q.pop_front();
            if (got !== e)
                report($sformatf("result %0d mismatch: expected %s, got %s",
                                 results_seen, show(e), show(got)));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_req          i_in_req    = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_req         o_out_req;

    pixel_scoreboard  sb = new();
    int               burst_left = 0;
    int               sent       = 0;
    t_stall_mode      stall_mode = STALL_NONE;
    int               mode_left  = 0;
    int               stall_tick = 0;

    alpha_over_compositor #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_req);
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 160);
        end else begin
            mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: i_out_stall <= (stall_tick % 5 < 2);
            default:        i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_layout(input int cw, input int ch, input int ow, input int oh,
                              input int sx, input int sy);
        put_reg(REG_CANVAS_W,  {1'($urandom_range(0, 1)), DIM_W'(cw)});
        put_reg(REG_CANVAS_H,  {1'($urandom_range(0, 1)), DIM_W'(ch)});
        put_reg(REG_OVERLAY_W, {1'($urandom_range(0, 1)), DIM_W'(ow)});
        put_reg(REG_OVERLAY_H, {1'($urandom_range(0, 1)), DIM_W'(oh)});
        put_reg(REG_SHIFT_X,   CFG_W'(sx));
        put_reg(REG_SHIFT_Y,   CFG_W'(sy));
        put_reg(REG_UNUSED,    CFG_W'($urandom));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input t_in_req px);
        i_in_req   <= px;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(px);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 20);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic end_phase();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in_req random_pixel();
        t_in_req px;
        px = t_in_req'({$urandom, $urandom});
        case ($urandom_range(0, 7))
            0: px.fg_alpha = '0;
            1: px.fg_alpha = '1;
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        int               cw;
        int               ch;
        int               ow;
        int               oh;
        int               sx;
        int               sy;
        logic [PIX_W-1:0] bg;
        logic [PIX_W-1:0] dir_alpha [12] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd255,
                                             8'd0, 8'd77, 8'd255, 8'd254, 8'd1, 8'd200};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel('0);
        send_pixel('1);
        end_phase();

        set_layout(4, 3, 2, 2, 1, 1);
        for (int i = 0; i < 12; i++) begin
            bg = (i % 2 == 1) ? '1 : '0;
            send_pixel({bg, bg, bg, bg, ~bg, ~bg, ~bg, dir_alpha[i]});
        end
        end_phase();

        // zero canvas clamps to a single pixel; extreme shifts miss the overlay
        set_layout(0, 0, 8191, 8191, -8192, 8191);
        repeat (2) send_pixel(random_pixel());
        end_phase();

        set_layout(0, 0, 1, 1, 0, 0);
        repeat (2) send_pixel(random_pixel());
        end_phase();

        set_layout(8191, 1, 4096, 0, 0, 0);
        repeat (3) send_pixel(random_pixel());
        end_phase();

        // shrink the canvas below the current column
        set_layout(2, 2, 2, 2, 0, 0);
        repeat (4) send_pixel(random_pixel());
        end_phase();

        while (sent < TOTAL_PIXELS) begin
            cw = $urandom_range(1, 12);
            ch = $urandom_range(1, 6);
            case ($urandom_range(0, 9))
                0: cw = 0;
                1: cw = 4096;
                2: ch = 0;
                3: ch = 8191;
                default: ;
            endcase
            ow = $urandom_range(0, 14);
            oh = $urandom_range(0, 8);
            sx = int'($urandom_range(0, 15)) - 3;
            sy = int'($urandom_range(0, 9)) - 3;
            case ($urandom_range(0, 7))
                0: begin ow = 4096; sx = 0; end
                1: begin ow = 8191; sx = -4096; end
                2: sx = 4096;
                3: sx = -8192;
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0: begin oh = 4096; sy = 0; end
                1: begin oh = 8191; sy = -4096; end
                2: sy = 4096;
                3: sy = 8191;
                default: ;
            endcase
            set_layout(cw, ch, ow, oh, sx, sy);
            repeat ($urandom_range(10, 70)) send_pixel(random_pixel());
            end_phase();
        end

        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
